### design/spm_pkg.sv
// Shared types and constants for the step pulse timing monitor.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package spm_pkg;

  // Width of the watched output word and of a bit index into it
  localparam int WORD_BITS    = 16;
  localparam int IDX_BITS     = 4;
  localparam int CFG_IDX_BITS = 4;
  localparam int CFG_DAT_BITS = 4;

  // Request kinds
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_STEP_ENABLE    = 4'd0,
    CFG_STEP_BIT_INDEX = 4'd1,
    CFG_DIR_ENABLE     = 4'd2,
    CFG_DIR_BIT_INDEX  = 4'd3
  } cfg_reg_t;

  typedef struct packed {
    logic                step_enable;
    logic [IDX_BITS-1:0] step_bit_index;
    logic                dir_enable;
    logic [IDX_BITS-1:0] dir_bit_index;
  } spm_cfg_t;

  // One incoming request
  typedef struct packed {
    logic                 req_type;
    logic [WORD_BITS-1:0] state_word;
    logic [31:0]          latch_time;
  } spm_in_t;

  // One result: the statistics after the request's update
  typedef struct packed {
    logic [31:0] rise_count;
    logic [31:0] dir_change_count;
    logic        dir_level;
    logic [31:0] period_count;
    logic [31:0] period_min;
    logic [31:0] period_max;
    logic [63:0] period_sum;
    logic [31:0] pulse_count;
    logic [31:0] pulse_min;
    logic [31:0] pulse_max;
    logic [63:0] pulse_sum;
  } spm_out_t;

endpackage

### design/step_pulse_timing_monitor.sv
// Step pulse timing monitor: rise, interval, high-time and direction statistics.
// From request accept to result valid: the input register takes the request, then the statistics
// register, which doubles as the result register, updates.
// Throughput: one request per cycle; in_stall follows out_stall when both stages hold.
// Reset (rst, synchronous): statistics set to reset values (minimums all ones), flags and config cleared, no result.
// Depends on spm_pkg, spm_cfg and spm_stats.
`timescale 1ns / 1ps

module step_pulse_timing_monitor (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  spm_pkg::spm_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output spm_pkg::spm_out_t                out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [spm_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [spm_pkg::CFG_DAT_BITS-1:0] cfg_data
);

  spm_pkg::spm_cfg_t cfg;
  spm_pkg::spm_in_t  s1_item;
  logic              s1_valid;
  logic              res_free;
  logic              adv;
  logic              in_take;

  spm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Handshake: result slot frees when empty or taken this cycle
  assign res_free = !out_valid || !out_stall;
  assign adv      = s1_valid && res_free;
  assign in_stall = s1_valid && !res_free;
  assign in_take  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item <= in_data;
    end
  end

  spm_stats u_stats (
    .clk   (clk),
    .rst   (rst),
    .adv   (adv),
    .item  (s1_item),
    .cfg   (cfg),
    .stats (out_data)
  );

  // Result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

### design/spm_cfg.sv
// Configuration register file of the step pulse timing monitor.
// Depends on spm_pkg for the register indexes and the config struct.
`timescale 1ns / 1ps

module spm_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [spm_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [spm_pkg::CFG_DAT_BITS-1:0]   cfg_data,
  output spm_pkg::spm_cfg_t                  cfg
);

  // Writes are taken in any cycle
  assign cfg_ready = 1'b1;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (spm_pkg::cfg_reg_t'(cfg_index))
        spm_pkg::CFG_STEP_ENABLE:    cfg.step_enable    <= cfg_data[0];
        spm_pkg::CFG_STEP_BIT_INDEX: cfg.step_bit_index <= cfg_data[spm_pkg::IDX_BITS-1:0];
        spm_pkg::CFG_DIR_ENABLE:     cfg.dir_enable     <= cfg_data[0];
        spm_pkg::CFG_DIR_BIT_INDEX:  cfg.dir_bit_index  <= cfg_data[spm_pkg::IDX_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

### design/spm_stats.sv
// Statistics state and its registered update for one request.
// Depends on spm_pkg for the request, result and config structs.
`timescale 1ns / 1ps

module spm_stats (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  spm_pkg::spm_in_t  item,
  input  spm_pkg::spm_cfg_t cfg,
  output spm_pkg::spm_out_t stats
);

  typedef struct packed {
    logic        prev_step_level;
    logic        seen_rise;
    logic [31:0] last_rise_time;
    logic        seen_dir;
    logic        dir_last;
    logic [31:0] rises;
    logic [31:0] dir_flips;
    logic [31:0] intervals;
    logic [31:0] interval_low;
    logic [31:0] interval_high;
    logic [63:0] interval_acc;
    logic [31:0] highs;
    logic [31:0] high_low;
    logic [31:0] high_high;
    logic [63:0] high_acc;
  } state_t;

  localparam state_t STATE_RESET = '{
    prev_step_level: 1'b0, seen_rise: 1'b0, last_rise_time: '0,
    seen_dir: 1'b0, dir_last: 1'b0, rises: '0, dir_flips: '0,
    intervals: '0, interval_low: '1, interval_high: '0, interval_acc: '0,
    highs: '0, high_low: '1, high_high: '0, high_acc: '0};

  state_t      st;
  state_t      st_next;
  logic        step_on;
  logic        dir_on;
  logic        step_lvl;
  logic        dir_bit;
  logic [31:0] delta;

  // Monitoring is on only for an index inside the word
  assign step_on  = cfg.step_enable &&
                    ({1'b0, cfg.step_bit_index} < (spm_pkg::IDX_BITS+1)'(spm_pkg::WORD_BITS));
  assign dir_on   = cfg.dir_enable &&
                    ({1'b0, cfg.dir_bit_index} < (spm_pkg::IDX_BITS+1)'(spm_pkg::WORD_BITS));
  assign step_lvl = item.state_word[cfg.step_bit_index];
  assign dir_bit  = item.state_word[cfg.dir_bit_index];
  assign delta    = item.latch_time - st.last_rise_time;

  // Edge detection and statistics update
  always_comb begin
    st_next = st;
    if (item.req_type == spm_pkg::REQ_CLEAR) begin
      st_next = STATE_RESET;
      st_next.prev_step_level = step_on & step_lvl;
    end else if (step_on && (step_lvl != st.prev_step_level)) begin
      st_next.prev_step_level = step_lvl;
      if (step_lvl) begin
        // rising edge: interval since last rise, direction tracking
        if (st.seen_rise) begin
          st_next.interval_acc = st.interval_acc + {32'd0, delta};
          st_next.intervals    = st.intervals + 32'd1;
          if (delta < st.interval_low)  st_next.interval_low  = delta;
          if (delta > st.interval_high) st_next.interval_high = delta;
        end
        st_next.last_rise_time = item.latch_time;
        st_next.seen_rise      = 1'b1;
        st_next.rises          = st.rises + 32'd1;
        if (dir_on) begin
          if (st.seen_dir && (dir_bit != st.dir_last)) begin
            st_next.dir_flips = st.dir_flips + 32'd1;
          end
          st_next.dir_last = dir_bit;
          st_next.seen_dir = 1'b1;
        end
      end else if (st.seen_rise) begin
        // falling edge: high time
        st_next.high_acc = st.high_acc + {32'd0, delta};
        st_next.highs    = st.highs + 32'd1;
        if (delta < st.high_low)  st_next.high_low  = delta;
        if (delta > st.high_high) st_next.high_high = delta;
      end
    end
  end

  // State advances only when the request moves into the result slot
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (adv) begin
      st <= st_next;
    end
  end

  // The updated state is the result
  assign stats = '{
    rise_count:       st.rises,
    dir_change_count: st.dir_flips,
    dir_level:        st.dir_last,
    period_count:     st.intervals,
    period_min:       st.interval_low,
    period_max:       st.interval_high,
    period_sum:       st.interval_acc,
    pulse_count:      st.highs,
    pulse_min:        st.high_low,
    pulse_max:        st.high_high,
    pulse_sum:        st.high_acc};

endmodule
